// File: src/multi_table_linear_interpolator_unit_assert.svh
// Assertion macros for the table interpolator RTL.
// Depends on clk and arst_n in the scope of the module that uses them.
`ifndef MULTI_TABLE_LINEAR_INTERPOLATOR_UNIT_ASSERT_SVH
`define MULTI_TABLE_LINEAR_INTERPOLATOR_UNIT_ASSERT_SVH
`define MTLI_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");
`define MTLI_ASSERT_ALWAYS(label, expr) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error("invariant check failed");
`endif

// File: src/mtli_pkg.sv
// Shared types and constants of the table interpolator.
// No dependencies.
package mtli_pkg;
	localparam int TABLE_DEPTH_DEF   = 1024;
	localparam int FRAC_BITS_DEF     = 8;
	localparam int VALUE_COLUMNS_DEF = 18;

	localparam logic ACT_LOAD = 1'b0;
	localparam logic ACT_EVAL = 1'b1;

	localparam logic [9:0] LAST_RESET = 10'd1023;

	localparam logic signed [24:0] VAL_MAX = 25'sh0FFFFFF;
	localparam logic signed [24:0] VAL_MIN = 25'sh1000000;

	typedef struct packed {
		logic               action;
		logic [4:0]         column;
		logic [9:0]         entry_index;
		logic signed [23:0] entry_value;
		logic signed [23:0] position;
	} cmd_t;

	typedef struct packed {
		logic signed [24:0] result_value;
		logic               clamped;
	} res_t;

	typedef struct packed {
		logic               grid_we;
		logic               val_we;
		logic [4:0]         column;
		logic [9:0]         row;
		logic signed [24:0] data;
	} store_wr_t;

	typedef struct packed {
		logic [4:0] column;
		logic [9:0] seg;
		logic [9:0] last;
	} store_rd_t;

	typedef struct packed {
		logic signed [23:0] xl;
		logic signed [23:0] xh;
		logic signed [23:0] xlast;
		logic signed [24:0] yl;
		logic signed [24:0] yh;
		logic signed [24:0] ylast;
	} store_data_t;

	typedef struct packed {
		logic               neg;
		logic               den_zero;
		logic               clamp;
		logic               has_col;
		logic signed [24:0] yl;
		logic signed [24:0] ylast;
	} div_side_t;
endpackage

// File: src/mtli_store.sv
// Grid and value column memories, three read copies each.
// Depends on mtli_pkg.
module mtli_store #(
	parameter int TABLE_DEPTH   = mtli_pkg::TABLE_DEPTH_DEF,
	parameter int VALUE_COLUMNS = mtli_pkg::VALUE_COLUMNS_DEF
) (
	input  logic                  clk,
	input  logic                  en,
	input  mtli_pkg::store_wr_t   wr,
	input  mtli_pkg::store_rd_t   rd,
	output mtli_pkg::store_data_t data_s2
);
	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int CW = (VALUE_COLUMNS > 1) ? $clog2(VALUE_COLUMNS) : 1;

	logic signed [23:0] grid_a [TABLE_DEPTH];
	logic signed [23:0] grid_b [TABLE_DEPTH];
	logic signed [23:0] grid_c [TABLE_DEPTH];
	logic signed [24:0] val_a [VALUE_COLUMNS][TABLE_DEPTH];
	logic signed [24:0] val_b [VALUE_COLUMNS][TABLE_DEPTH];
	logic signed [24:0] val_c [VALUE_COLUMNS][TABLE_DEPTH];

	logic [AW-1:0] wr_row, rd_seg, rd_seg1, rd_last;
	logic [CW-1:0] wr_col, rd_col;
	logic [9:0]    seg1;

	assign seg1    = rd.seg + 10'd1;
	assign wr_row  = AW'(wr.row);
	assign rd_seg  = AW'(rd.seg);
	assign rd_seg1 = AW'(seg1);
	assign rd_last = AW'(rd.last);
	assign wr_col  = CW'(wr.column - 5'd1);
	assign rd_col  = CW'(rd.column - 5'd1);

	always_ff @(posedge clk) begin
		if (wr.grid_we) begin
			grid_a[wr_row] <= wr.data[23:0];
			grid_b[wr_row] <= wr.data[23:0];
			grid_c[wr_row] <= wr.data[23:0];
		end
		if (wr.val_we) begin
			val_a[wr_col][wr_row] <= wr.data;
			val_b[wr_col][wr_row] <= wr.data;
			val_c[wr_col][wr_row] <= wr.data;
		end
		if (en) begin
			data_s2.xl    <= grid_a[rd_seg];
			data_s2.xh    <= grid_b[rd_seg1];
			data_s2.xlast <= grid_c[rd_last];
			data_s2.yl    <= val_a[rd_col][rd_seg];
			data_s2.yh    <= val_b[rd_col][rd_seg1];
			data_s2.ylast <= val_c[rd_col][rd_last];
		end
	end
endmodule

// File: src/mtli_div.sv
// Pipelined restoring divider, one quotient bit per stage, with side payload.
// Depends on nothing but its parameters.
module mtli_div #(
	parameter int NW = 52,
	parameter int DW = 25,
	parameter int SW = 54
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_valid,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	input  logic [SW-1:0] side_in,
	output logic          out_valid,
	output logic [NW-1:0] quo,
	output logic [SW-1:0] side_out
);
	logic          v_q    [NW+1];
	logic [DW:0]   rem_q  [NW+1];
	logic [NW-1:0] num_q  [NW+1];
	logic [NW-1:0] quo_q  [NW+1];
	logic [DW-1:0] den_q  [NW+1];
	logic [SW-1:0] side_q [NW+1];

	assign v_q[0]    = in_valid;
	assign rem_q[0]  = '0;
	assign num_q[0]  = num;
	assign quo_q[0]  = '0;
	assign den_q[0]  = den;
	assign side_q[0] = side_in;

	for (genvar k = 0; k < NW; k++) begin : g_stage
		logic [DW:0] sh;
		logic        ge;
		assign sh = {rem_q[k][DW-1:0], num_q[k][NW-1]};
		assign ge = sh >= {1'b0, den_q[k]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_q[k+1] <= 1'b0;
			end else if (en) begin
				v_q[k+1] <= v_q[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_q[k+1]  <= ge ? (sh - {1'b0, den_q[k]}) : sh;
				num_q[k+1]  <= num_q[k] << 1;
				quo_q[k+1]  <= {quo_q[k][NW-2:0], ge};
				den_q[k+1]  <= den_q[k];
				side_q[k+1] <= side_q[k];
			end
		end
	end

	assign out_valid = v_q[NW];
	assign quo       = quo_q[NW];
	assign side_out  = side_q[NW];
endmodule

// File: src/multi_table_linear_interpolator_unit.sv
// Piecewise linear interpolation over a grid column and value columns loaded one entry per
// transaction. An evaluate transaction enters every cycle unless the output is stalled; its
// result passes through one input stage, a registered memory read, a difference stage, a
// multiply stage, a 52-stage divider (one quotient bit per stage) and an output register.
// Loads write the memories at acceptance and give no result. A stalled output freezes the
// whole pipeline.
// Depends on mtli_pkg, mtli_store, mtli_div and the assertion header.
`include "multi_table_linear_interpolator_unit_assert.svh"

module multi_table_linear_interpolator_unit #(
	parameter int TABLE_DEPTH   = mtli_pkg::TABLE_DEPTH_DEF,
	parameter int FRAC_BITS     = mtli_pkg::FRAC_BITS_DEF,
	parameter int VALUE_COLUMNS = mtli_pkg::VALUE_COLUMNS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cfg_we,
	input  logic [9:0]     cfg_wdata,
	input  logic           cmd_valid,
	output logic           cmd_ready,
	input  mtli_pkg::cmd_t cmd,
	output logic           res_valid,
	input  logic           res_ready,
	output mtli_pkg::res_t res
);
	localparam int NW = 52;
	localparam int DW = 25;
	localparam int SW = $bits(mtli_pkg::div_side_t);
	localparam int HALF_COLS = VALUE_COLUMNS / 2;

	logic       en, accept, load, has_col, row_ok;
	logic [9:0] last_q, last_eff, lim, seg;
	logic [23:0] pos_u, p_abs, seg_raw;

	mtli_pkg::store_wr_t   wr;
	mtli_pkg::store_rd_t   rd_s1;
	mtli_pkg::store_data_t data_s2;

	logic        v_s1, v_s2, v_s3, v_s4;
	logic [23:0] p_s1, p_s2;
	logic        has_col_s1, has_col_s2, has_col_s3, has_col_s4;
	logic        clamp_s3, clamp_s4;
	logic signed [25:0] dx_s3, dy_s3;
	logic signed [24:0] den_s3, den_s4, yl_s3, yl_s4, ylast_s3, ylast_s4;
	logic signed [51:0] prod_s4;

	logic [NW-1:0] num_mag, quo;
	logic [DW-1:0] den_mag;
	mtli_pkg::div_side_t side_in, side_out;
	logic [SW-1:0] side_out_w;
	logic          div_valid;

	logic signed [52:0] q_s, sum;
	logic signed [24:0] result;
	logic               res_valid_q;
	mtli_pkg::res_t     res_q;

	assign en        = !res_valid_q || res_ready;
	assign cmd_ready = en;
	assign accept    = cmd_valid && en;
	assign load      = accept && (cmd.action == mtli_pkg::ACT_LOAD);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q <= mtli_pkg::LAST_RESET;
		end else if (cfg_we) begin
			last_q <= cfg_wdata;
		end
	end

	always_comb begin
		if (last_q == 10'd0) begin
			last_eff = 10'd1;
		end else if (32'(last_q) > TABLE_DEPTH - 1) begin
			last_eff = 10'(TABLE_DEPTH - 1);
		end else begin
			last_eff = last_q;
		end
	end

	assign pos_u   = cmd.position;
	assign p_abs   = pos_u[23] ? (~pos_u + 24'd1) : pos_u;
	assign seg_raw = p_abs >> FRAC_BITS;
	assign lim     = last_eff - 10'd1;
	assign seg     = (seg_raw > {14'd0, lim}) ? lim : seg_raw[9:0];
	assign has_col = (cmd.column != 5'd0) && (32'(cmd.column) <= VALUE_COLUMNS);
	assign row_ok  = 32'(cmd.entry_index) < TABLE_DEPTH;

	always_comb begin
		wr.grid_we = load && row_ok && (cmd.column == 5'd0);
		wr.val_we  = load && row_ok && has_col;
		wr.column  = cmd.column;
		wr.row     = cmd.entry_index;
		if (cmd.column != 5'd0 && 32'(cmd.column) <= HALF_COLS) begin
			wr.data = {cmd.entry_value, 1'b0};
		end else begin
			wr.data = {cmd.entry_value[23], cmd.entry_value};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			res_valid_q <= 1'b0;
		end else if (en) begin
			v_s1        <= accept && (cmd.action == mtli_pkg::ACT_EVAL);
			v_s2        <= v_s1;
			v_s3        <= v_s2;
			v_s4        <= v_s3;
			res_valid_q <= div_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_s1         <= p_abs;
			has_col_s1   <= has_col;
			rd_s1.column <= cmd.column;
			rd_s1.seg    <= seg;
			rd_s1.last   <= last_eff;

			p_s2       <= p_s1;
			has_col_s2 <= has_col_s1;

			clamp_s3   <= $signed({1'b0, p_s2}) >= $signed({data_s2.xlast[23], data_s2.xlast});
			dx_s3      <= $signed({2'b00, p_s2}) - $signed({{2{data_s2.xl[23]}}, data_s2.xl});
			dy_s3      <= $signed({data_s2.yh[24], data_s2.yh})
				- $signed({data_s2.yl[24], data_s2.yl});
			den_s3     <= $signed({data_s2.xh[23], data_s2.xh})
				- $signed({data_s2.xl[23], data_s2.xl});
			yl_s3      <= data_s2.yl;
			ylast_s3   <= data_s2.ylast;
			has_col_s3 <= has_col_s2;

			prod_s4    <= dx_s3 * dy_s3;
			den_s4     <= den_s3;
			yl_s4      <= yl_s3;
			ylast_s4   <= ylast_s3;
			clamp_s4   <= clamp_s3;
			has_col_s4 <= has_col_s3;

			res_q.result_value <= result;
			res_q.clamped      <= side_out.clamp;
		end
	end

	mtli_store #(
		.TABLE_DEPTH  (TABLE_DEPTH),
		.VALUE_COLUMNS(VALUE_COLUMNS)
	) u_store (
		.clk    (clk),
		.en     (en),
		.wr     (wr),
		.rd     (rd_s1),
		.data_s2(data_s2)
	);

	assign num_mag = prod_s4[51] ? NW'(~prod_s4 + 52'sd1) : NW'(prod_s4);
	assign den_mag = den_s4[24] ? DW'(~den_s4 + 25'sd1) : DW'(den_s4);

	always_comb begin
		side_in.neg      = prod_s4[51] ^ den_s4[24];
		side_in.den_zero = den_s4 == 25'sd0;
		side_in.clamp    = clamp_s4;
		side_in.has_col  = has_col_s4;
		side_in.yl       = yl_s4;
		side_in.ylast    = ylast_s4;
	end

	mtli_div #(
		.NW(NW),
		.DW(DW),
		.SW(SW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (v_s4),
		.num      (num_mag),
		.den      (den_mag),
		.side_in  (side_in),
		.out_valid(div_valid),
		.quo      (quo),
		.side_out (side_out_w)
	);

	assign side_out = side_out_w;
	assign q_s      = side_out.neg ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
	assign sum      = q_s + $signed({{28{side_out.yl[24]}}, side_out.yl});

	always_comb begin
		if (side_out.clamp) begin
			result = side_out.has_col ? side_out.ylast : 25'sd0;
		end else if (!side_out.has_col) begin
			result = 25'sd0;
		end else if (side_out.den_zero) begin
			result = side_out.yl;
		end else if (sum > 53'(mtli_pkg::VAL_MAX)) begin
			result = mtli_pkg::VAL_MAX;
		end else if (sum < 53'(mtli_pkg::VAL_MIN)) begin
			result = mtli_pkg::VAL_MIN;
		end else begin
			result = sum[24:0];
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

	`MTLI_ASSERT_NEXT(a_load_no_result, load, !v_s1)
	`MTLI_ASSERT_NEXT(a_stall_freeze, !en, $stable(v_s1) && $stable(v_s4) && $stable(res_q))
	`MTLI_ASSERT_ALWAYS(a_last_in_range, last_eff != 10'd0)
endmodule
